>>> design/qwv_pkg.sv
// qwv_pkg: widths, state and operation codes, and the step decode table
// for the quadrature window velocity block. no dependencies.
package qwv_pkg;

  localparam int unsigned RING_DEPTH_DEF = 64;
  localparam int unsigned SLOT_W = 6;
  localparam int unsigned BITS_W = 2;
  localparam int unsigned SUM_W  = 16;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned CMP_W  = 9;

  typedef enum logic [1:0] {
    STEP_NONE = 2'b00,
    STEP_FWD  = 2'b01,
    STEP_BACK = 2'b10,
    STEP_JUMP = 2'b11
  } step_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CLOSE,
    ST_DECODE
  } seq_state_e;

  typedef enum logic {
    ALU_CLOSE,
    ALU_STEP
  } alu_op_e;

  typedef struct packed {
    alu_op_e            op;
    logic [SUM_W-1:0]   sum;
    logic [CNT_W-1:0]   open;
    logic [CNT_W-1:0]   old;
    step_e              kind;
  } alu_req_t;

  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [CNT_W-1:0]   open;
  } alu_rsp_t;

  // indexed by previous bits and new bits
  function automatic step_e step_kind(input logic [2*BITS_W-1:0] idx);
    step_e k;
    unique case (idx)
      4'h0, 4'h5, 4'hA, 4'hF: k = STEP_NONE;
      4'h1, 4'h7, 4'h8, 4'hE: k = STEP_FWD;
      4'h2, 4'h4, 4'hB, 4'hD: k = STEP_BACK;
      default:                k = STEP_JUMP;
    endcase
    return k;
  endfunction

endpackage

>>> design/qwv_in_if.sv
// qwv_in_if: sample request channel, time slot and encoder bits.
// depends on qwv_pkg.
interface qwv_in_if import qwv_pkg::*; ;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] time_slot;
  logic [BITS_W-1:0] enc_bits;

  modport source (output valid, time_slot, enc_bits, input ready);
  modport sink   (input valid, time_slot, enc_bits, output ready);
endinterface

>>> design/qwv_out_if.sv
// qwv_out_if: result request channel, window sum and counters.
// depends on qwv_pkg.
interface qwv_out_if import qwv_pkg::*; ;
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] window_sum;
  logic signed [CNT_W-1:0] slot_count;
  logic        [CNT_W-1:0] skip_count;
  logic        [CNT_W-1:0] double_count;

  modport source (output valid, window_sum, slot_count, skip_count, double_count,
                  input ready);
  modport sink   (input valid, window_sum, slot_count, skip_count, double_count,
                  output ready);
endinterface

>>> design/qwv_ring.sv
// qwv_ring: per-slot count memory with registered read and valid bits,
// unwritten entries read as zero. depends on qwv_pkg.
module qwv_ring import qwv_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
  parameter int unsigned PTR_W      = $clog2(RING_DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [PTR_W-1:0] rd_addr_i,
  output logic [CNT_W-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [PTR_W-1:0] wr_addr_i,
  input  logic [CNT_W-1:0] wr_data_i
);

  logic [CNT_W-1:0]      mem [RING_DEPTH];
  logic [RING_DEPTH-1:0] vld_q;
  logic [CNT_W-1:0]      rd_q;
  logic                  rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_q <= mem[rd_addr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

>>> design/qwv_alu.sv
// qwv_alu: shared 16-bit adder for slot closing and step decoding.
// depends on qwv_pkg.
module qwv_alu import qwv_pkg::*; (
  input  alu_req_t req_i,
  output alu_rsp_t rsp_o
);

  logic [CNT_W:0]   diff;
  logic [SUM_W-1:0] op_a;
  logic [SUM_W-1:0] op_b;
  logic [SUM_W-1:0] res;
  logic             positive;

  always_comb begin
    diff     = {req_i.open[CNT_W-1], req_i.open} - {req_i.old[CNT_W-1], req_i.old};
    positive = (req_i.open != '0) && !req_i.open[CNT_W-1];
    op_a     = '0;
    op_b     = '0;
    unique case (req_i.op)
      ALU_CLOSE: begin
        op_a = req_i.sum;
        op_b = {{(SUM_W-CNT_W-1){diff[CNT_W]}}, diff};
      end
      ALU_STEP: begin
        op_a = {{(SUM_W-CNT_W){req_i.open[CNT_W-1]}}, req_i.open};
        unique case (req_i.kind)
          STEP_NONE: op_b = '0;
          STEP_FWD:  op_b = SUM_W'(1);
          STEP_BACK: op_b = '1;
          STEP_JUMP: op_b = positive ? SUM_W'(2) : ~SUM_W'(1);
        endcase
      end
    endcase
    res = op_a + op_b;
    if (req_i.op == ALU_CLOSE) begin
      rsp_o.sum  = res;
      rsp_o.open = '0;
    end else begin
      rsp_o.sum  = req_i.sum;
      rsp_o.open = res[CNT_W-1:0];
    end
  end

endmodule

>>> design/quadrature_window_velocity.sv
// quadrature_window_velocity: top level, sequencer and state registers.
// depends on qwv_pkg, qwv_in_if, qwv_out_if, qwv_ring and qwv_alu.
//
// One quadrature channel with a moving-window pulse count. Each sample request
// brings the current time slot and the A/B bits; every slot from the ring
// pointer up to that slot is closed (its stored count leaves the window sum,
// the open count enters it and is stored), then the bit change is decoded into
// the open count. A sample passes the check state, which subtracts RING_DEPTH
// until the slot lies in the ring (never when RING_DEPTH is 64 or more), the
// close state once per slot closed and the decode state, which waits while the
// output holds an earlier result not yet taken, then returns to idle. The
// sequencer closes one slot per cycle through the ring memory's registered read
// port and the shared adder. A new sample is accepted as soon as the sequencer
// is idle, while an earlier result may still wait on the output.
module quadrature_window_velocity import qwv_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  qwv_in_if.sink   sample_i,
  qwv_out_if.source result_o
);

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam logic [CMP_W-1:0]  DEPTH_CMP  = CMP_W'(RING_DEPTH);
  localparam logic [SLOT_W-1:0] DEPTH_SLOT = SLOT_W'(RING_DEPTH);
  localparam logic [PTR_W-1:0]  PTR_LAST   = PTR_W'(RING_DEPTH - 1);

  seq_state_e        st_q, st_d;
  logic [PTR_W-1:0]  ptr_q, ptr_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [BITS_W-1:0] bits_q, bits_d;
  logic [BITS_W-1:0] prev_q, prev_d;
  logic [CNT_W-1:0]  open_q, open_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  skip_q, skip_d;
  logic [CNT_W-1:0]  dbl_q, dbl_d;

  logic              out_valid_q, out_valid_d;
  logic [SUM_W-1:0]  out_sum_q, out_sum_d;
  logic [CNT_W-1:0]  out_open_q, out_open_d;
  logic [CNT_W-1:0]  out_skip_q, out_skip_d;
  logic [CNT_W-1:0]  out_dbl_q, out_dbl_d;

  logic [PTR_W-1:0]  ptr_inc;
  logic [PTR_W-1:0]  rd_addr;
  logic [CNT_W-1:0]  rd_data;
  logic              wr_en;
  alu_req_t          alu_req;
  alu_rsp_t          alu_rsp;
  step_e             kind;

  qwv_ring #(
    .RING_DEPTH (RING_DEPTH),
    .PTR_W      (PTR_W)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (ptr_q),
    .wr_data_i (open_q)
  );

  qwv_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign ptr_inc        = (ptr_q == PTR_LAST) ? '0 : ptr_q + 1'b1;
  assign kind           = step_kind({prev_q, bits_q});
  assign sample_i.ready = (st_q == ST_IDLE);

  always_comb begin
    st_d        = st_q;
    ptr_d       = ptr_q;
    slot_d      = slot_q;
    bits_d      = bits_q;
    prev_d      = prev_q;
    open_d      = open_q;
    sum_d       = sum_q;
    skip_d      = skip_q;
    dbl_d       = dbl_q;
    out_valid_d = out_valid_q && !result_o.ready;
    out_sum_d   = out_sum_q;
    out_open_d  = out_open_q;
    out_skip_d  = out_skip_q;
    out_dbl_d   = out_dbl_q;
    rd_addr     = ptr_q;
    wr_en       = 1'b0;
    alu_req.op   = ALU_STEP;
    alu_req.sum  = sum_q;
    alu_req.open = open_q;
    alu_req.old  = rd_data;
    alu_req.kind = kind;

    unique case (st_q)
      ST_IDLE: begin
        if (sample_i.valid) begin
          slot_d = sample_i.time_slot;
          bits_d = sample_i.enc_bits;
          st_d   = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (CMP_W'(slot_q) >= DEPTH_CMP) begin
          slot_d = slot_q - DEPTH_SLOT;
        end else if (CMP_W'(slot_q) == CMP_W'(ptr_q)) begin
          st_d = ST_DECODE;
        end else begin
          st_d = ST_CLOSE;
        end
      end
      ST_CLOSE: begin
        alu_req.op = ALU_CLOSE;
        wr_en      = 1'b1;
        sum_d      = alu_rsp.sum;
        open_d     = alu_rsp.open;
        ptr_d      = ptr_inc;
        rd_addr    = ptr_inc;
        if (CMP_W'(ptr_inc) == CMP_W'(slot_q)) begin
          st_d = ST_DECODE;
        end else begin
          skip_d = skip_q + 1'b1;
        end
      end
      ST_DECODE: begin
        if (!out_valid_q || result_o.ready) begin
          open_d = alu_rsp.open;
          prev_d = bits_q;
          if (kind == STEP_JUMP) begin
            dbl_d = dbl_q + 1'b1;
          end
          out_valid_d = 1'b1;
          out_sum_d   = sum_q;
          out_open_d  = alu_rsp.open;
          out_skip_d  = skip_q;
          out_dbl_d   = dbl_d;
          st_d        = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ptr_q       <= '0;
      prev_q      <= '0;
      open_q      <= '0;
      sum_q       <= '0;
      skip_q      <= '0;
      dbl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      ptr_q       <= ptr_d;
      prev_q      <= prev_d;
      open_q      <= open_d;
      sum_q       <= sum_d;
      skip_q      <= skip_d;
      dbl_q       <= dbl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q     <= slot_d;
    bits_q     <= bits_d;
    out_sum_q  <= out_sum_d;
    out_open_q <= out_open_d;
    out_skip_q <= out_skip_d;
    out_dbl_q  <= out_dbl_d;
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.window_sum   = out_sum_q;
  assign result_o.slot_count   = out_open_q;
  assign result_o.skip_count   = out_skip_q;
  assign result_o.double_count = out_dbl_q;

  // pointer stays inside the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMP_W'(ptr_q) < DEPTH_CMP)
    else $error("ring pointer out of range");

  // a slot is only closed while the pointer has not reached the slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CLOSE) |-> (CMP_W'(ptr_q) != CMP_W'(slot_q)))
    else $error("closing at the target slot");

  // skip counter moves only while closing slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_CLOSE) |=> (skip_q == $past(skip_q)))
    else $error("skip count changed outside catch-up");

  // a new result appears only from the decode step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(st_q) == ST_DECODE))
    else $error("result raised outside decode");

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// tb_top: self-checking testbench for quadrature_window_velocity, predicting
// each result from its own copy of the slot ring and counters.
// depends on qwv_pkg, qwv_in_if, qwv_out_if and the quadrature_window_velocity rtl.
module tb_top;
  import qwv_pkg::*;

  localparam int unsigned RING = RING_DEPTH_DEF;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned RANDOM_SAMPLES = 190;

  typedef struct packed {
    logic signed [SUM_W-1:0] window_sum;
    logic signed [CNT_W-1:0] slot_count;
    logic        [CNT_W-1:0] skip_count;
    logic        [CNT_W-1:0] double_count;
  } velocity_t;

  logic clk_i;
  logic rst_ni;

  qwv_in_if  sample_if ();
  qwv_out_if result_if ();

  quadrature_window_velocity dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .result_o (result_if)
  );

  // predictor state
  logic signed [CNT_W-1:0] ring_counts [RING];
  logic [SLOT_W-1:0]       ring_ptr;
  logic signed [CNT_W-1:0] open_cnt;
  logic [SUM_W-1:0]        win_sum;
  logic [BITS_W-1:0]       last_bits;
  logic [CNT_W-1:0]        skip_total;
  logic [CNT_W-1:0]        double_total;

  velocity_t expected_velocity_q [$];
  bit        failed;
  int        burst_left;
  int        hold_off_cycles;
  int        idle_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [1:0] gray_pos(input logic [BITS_W-1:0] bits);
    case (bits)
      2'b00:   return 2'd0;
      2'b01:   return 2'd1;
      2'b11:   return 2'd2;
      default: return 2'd3;
    endcase
  endfunction

  function automatic logic [BITS_W-1:0] gray_bits(input logic [1:0] pos);
    case (pos)
      2'd0:    return 2'b00;
      2'd1:    return 2'b01;
      2'd2:    return 2'b11;
      default: return 2'b10;
    endcase
  endfunction

  // bits reached from the last accepted bits after a number of forward steps
  function automatic logic [BITS_W-1:0] bits_after(input logic [1:0] steps);
    return gray_bits(gray_pos(last_bits) + steps);
  endfunction

  function automatic void predict_velocity(input logic [SLOT_W-1:0] slot,
                                           input logic [BITS_W-1:0] bits,
                                           output velocity_t res);
    logic [1:0] delta;
    step_e      kind;
    // close every slot up to the requested one
    while (ring_ptr != slot) begin
      win_sum = win_sum + {{(SUM_W-CNT_W){open_cnt[CNT_W-1]}}, open_cnt}
                        - {{(SUM_W-CNT_W){ring_counts[ring_ptr][CNT_W-1]}},
                           ring_counts[ring_ptr]};
      ring_counts[ring_ptr] = open_cnt;
      open_cnt = '0;
      ring_ptr = ring_ptr + 1'b1;
      if (ring_ptr != slot) skip_total = skip_total + 1'b1;
    end
    delta = gray_pos(bits) - gray_pos(last_bits);
    case (delta)
      2'd0:    kind = STEP_NONE;
      2'd1:    kind = STEP_FWD;
      2'd3:    kind = STEP_BACK;
      default: kind = STEP_JUMP;
    endcase
    case (kind)
      STEP_FWD:  open_cnt = open_cnt + 8'sd1;
      STEP_BACK: open_cnt = open_cnt - 8'sd1;
      STEP_JUMP: begin
        // direction of a jump follows the sign of the open count
        if (open_cnt > 0) open_cnt = open_cnt + 8'sd2;
        else open_cnt = open_cnt - 8'sd2;
        double_total = double_total + 1'b1;
      end
      default: ;
    endcase
    last_bits = bits;
    res.window_sum   = win_sum;
    res.slot_count   = open_cnt;
    res.skip_count   = skip_total;
    res.double_count = double_total;
  endfunction

  task automatic send_sample(input logic [SLOT_W-1:0] slot, input logic [BITS_W-1:0] bits);
    velocity_t res;
    int        gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      sample_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    sample_if.valid     <= 1'b1;
    sample_if.time_slot <= slot;
    sample_if.enc_bits  <= bits;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    burst_left--;
    predict_velocity(slot, bits, res);
    expected_velocity_q.push_back(res);
  endtask

  task automatic wait_results_drained();
    sample_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_velocity_q.size() != 0) @(posedge clk_i);
  endtask

  // every previous/new bit pair once, in the open slot at reset
  task automatic test_step_decode();
    logic [BITS_W-1:0] walk [16];
    walk = '{2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd1, 2'd1,
             2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0};
    foreach (walk[i]) send_sample(ring_ptr, walk[i]);
  endtask

  task automatic test_jump_sign();
    send_sample(ring_ptr + 1'b1, last_bits);
    send_sample(ring_ptr, bits_after(2'd1));
    send_sample(ring_ptr, bits_after(2'd1));
    send_sample(ring_ptr, bits_after(2'd2));
    // zero and negative open count on a jump
    send_sample(ring_ptr + 1'b1, last_bits);
    send_sample(ring_ptr, bits_after(2'd2));
    send_sample(ring_ptr, bits_after(2'd2));
  endtask

  task automatic test_slot_skips();
    send_sample(ring_ptr + 1'b1, bits_after(2'd1));
    send_sample(ring_ptr + 6'd5, bits_after(2'd3));
    send_sample(6'd63, bits_after(2'd1));
    // full lap around the ring
    send_sample(ring_ptr - 1'b1, bits_after(2'd1));
    send_sample(6'd0, bits_after(2'd3));
  endtask

  // open count wraps past its positive limit, then a jump from a negative count
  task automatic test_count_wrap();
    send_sample(ring_ptr + 1'b1, last_bits);
    repeat (132) send_sample(ring_ptr, bits_after(2'd1));
    send_sample(ring_ptr, bits_after(2'd2));
    repeat (8) send_sample(ring_ptr, bits_after(2'd3));
    send_sample(ring_ptr + 1'b1, bits_after(2'd3));
  endtask

  task automatic random_sample();
    logic [SLOT_W-1:0] slot;
    logic [BITS_W-1:0] bits;
    int                pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) slot = ring_ptr;
    else if (pick < 85) slot = ring_ptr + 1'b1;
    else if (pick < 95) slot = ring_ptr + SLOT_W'($urandom_range(2, 8));
    else slot = SLOT_W'($urandom_range(0, RING - 1));
    pick = $urandom_range(0, 99);
    if (pick < 15) bits = BITS_W'($urandom_range(0, 3));
    else if (pick < 55) bits = bits_after(2'd1);
    else if (pick < 80) bits = bits_after(2'd3);
    else if (pick < 90) bits = bits_after(2'd2);
    else bits = last_bits;
    send_sample(slot, bits);
  endtask

  task automatic test_random();
    repeat (RANDOM_SAMPLES) random_sample();
  endtask

  // receiver holds off long enough for the block to stall its input
  task automatic test_backpressure();
    hold_off_cycles = 300;
    repeat (20) random_sample();
    wait_results_drained();
    repeat (20) random_sample();
  endtask

  initial begin
    rst_ni              = 1'b0;
    sample_if.valid     = 1'b0;
    sample_if.time_slot = '0;
    sample_if.enc_bits  = '0;
    failed              = 1'b0;
    burst_left          = 0;
    hold_off_cycles     = 0;
    foreach (ring_counts[i]) ring_counts[i] = '0;
    ring_ptr     = '0;
    open_cnt     = '0;
    win_sum      = '0;
    last_bits    = '0;
    skip_total   = '0;
    double_total = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_step_decode();
    test_jump_sign();
    test_slot_skips();
    test_count_wrap();
    test_random();
    test_backpressure();

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (!failed) begin
      $display("quadrature_window_velocity: match");
    end else begin
      $display("quadrature_window_velocity: mismatch");
    end
    $finish;
  end

  // receiver stall pattern
  initial begin
    int stall_left;
    int stall_mode;
    int phase;
    result_if.ready = 1'b0;
    stall_left = 0;
    stall_mode = 0;
    phase      = 0;
    forever begin
      @(posedge clk_i);
      phase++;
      if (hold_off_cycles > 0) begin
        result_if.ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        if (stall_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          stall_left = $urandom_range(10, 60);
        end
        stall_left--;
        case (stall_mode)
          0:       result_if.ready <= 1'b1;
          1:       result_if.ready <= 1'($urandom_range(0, 1));
          2:       result_if.ready <= ($urandom_range(0, 3) == 0);
          default: result_if.ready <= (phase % 3 != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    velocity_t exp_res;
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (expected_velocity_q.size() == 0) begin
        $error("unexpected result: window_sum %0d", result_if.window_sum);
        failed = 1'b1;
      end else begin
        exp_res = expected_velocity_q.pop_front();
        if (result_if.window_sum !== exp_res.window_sum) begin
          $error("window_sum: expected %0d, got %0d", exp_res.window_sum,
                 result_if.window_sum);
          failed = 1'b1;
        end
        if (result_if.slot_count !== exp_res.slot_count) begin
          $error("slot_count: expected %0d, got %0d", exp_res.slot_count,
                 result_if.slot_count);
          failed = 1'b1;
        end
        if (result_if.skip_count !== exp_res.skip_count) begin
          $error("skip_count: expected %0d, got %0d", exp_res.skip_count,
                 result_if.skip_count);
          failed = 1'b1;
        end
        if (result_if.double_count !== exp_res.double_count) begin
          $error("double_count: expected %0d, got %0d", exp_res.double_count,
                 result_if.double_count);
          failed = 1'b1;
        end
      end
    end
  end

  // watchdog on cycles with no request accepted on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (sample_if.valid && sample_if.ready) ||
        (result_if.valid && result_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("quadrature_window_velocity: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
